// ===== hw/rtl/fra_pkg.sv =====
`timescale 1ns / 1ps

package fra_pkg;

    // Fixed widths of the result fields.
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    // Action decoding: bit 1 alone selects multiply, otherwise add or subtract.
    localparam int         ACT_MUL_BIT = 1;
    localparam logic [1:0] ACT_SUB     = 2'd1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_STORE_A,
        OP_STORE_B,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_GCD_GO,
        OP_DIV_GO,
        OP_DIV_WB,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   div_short;
    } t_dp_cmd;

    typedef struct packed {
        logic work_zero;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/fra_if.sv =====
`timescale 1ns / 1ps

interface fra_in_if #(
    parameter int OPERAND_WIDTH = 16
) ();
    logic                            valid;
    logic                            ready;
    logic        [1:0]               action;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (
        output valid, action, a_num, a_den, b_num, b_den,
        input  ready
    );
    modport sink (
        input  valid, action, a_num, a_den, b_num, b_den,
        output ready
    );
endinterface

interface fra_out_if import fra_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic        [RES_DEN_W-1:0] res_den;

    modport source (
        output valid, res_num, res_den,
        input  ready
    );
    modport sink (
        input  valid, res_num, res_den,
        output ready
    );
endinterface

// ===== hw/rtl/fra_gcd.sv =====
`timescale 1ns / 1ps

// Binary (Stein) GCD: one shift or one subtract per cycle.
module fra_gcd #(
    parameter int MW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_x,
    input  logic [MW-1:0] i_y,
    output logic          o_done,
    output logic [MW-1:0] o_g
);

    localparam int KW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [KW-1:0] r_k;
    logic [MW-1:0] r_g;

    logic [MW-1:0] n_x;
    logic [MW-1:0] n_y;
    logic [KW-1:0] n_k;
    logic          fin;

    assign fin = (r_x == '0) || (r_y == '0);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        priority if (!r_x[0] && !r_y[0]) begin
            n_x = r_x >> 1;
            n_y = r_y >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_x[0]) begin
            n_x = r_x >> 1;
        end else if (!r_y[0]) begin
            n_y = r_y >> 1;
        end else if (r_x >= r_y) begin
            n_x = r_x - r_y;
        end else begin
            n_y = r_y - r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && fin) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_busy && !fin) begin
            r_x <= n_x;
            r_y <= n_y;
            r_k <= n_k;
        end else if (r_busy && fin) begin
            // One of the two is zero, so the OR is the other one.
            r_g <= (r_x | r_y) << r_k;
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

    a_g_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_g != '0)
        else $error("GCD finished with a zero divisor.");

endmodule

// ===== hw/rtl/fra_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, two dividends sharing one divisor.
// In short mode the dividends are known to fit in SW bits and only SW steps run.
module fra_div #(
    parameter int MW = 33,
    parameter int SW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_short,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    input  logic [MW-1:0] i_g,
    output logic          o_done,
    output logic [MW-1:0] o_q_num,
    output logic [MW-1:0] o_q_den
);

    localparam int CW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_g;
    logic [MW-1:0] r_qn;
    logic [MW-1:0] r_qd;
    logic [MW-1:0] r_rn;
    logic [MW-1:0] r_rd;

    logic [2*MW-1:0] n_lane_n;
    logic [2*MW-1:0] n_lane_d;

    function automatic logic [2*MW-1:0] div_step(input logic [MW-1:0] rem,
                                                 input logic [MW-1:0] quo,
                                                 input logic [MW-1:0] dvs);
        logic [MW:0] sh;
        logic [MW:0] df;
        logic        ge;
        sh = {rem, quo[MW-1]};
        ge = sh >= {1'b0, dvs};
        df = sh - {1'b0, dvs};
        div_step = ge ? {df[MW-1:0], quo[MW-2:0], 1'b1}
                      : {sh[MW-1:0], quo[MW-2:0], 1'b0};
    endfunction

    assign n_lane_n = div_step(r_rn, r_qn, r_g);
    assign n_lane_d = div_step(r_rd, r_qd, r_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? CW'(SW) : CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_g  <= i_g;
            r_rn <= '0;
            r_rd <= '0;
            r_qn <= i_short ? (i_num << (MW - SW)) : i_num;
            r_qd <= i_short ? (i_den << (MW - SW)) : i_den;
        end else if (r_busy) begin
            {r_rn, r_qn} <= n_lane_n;
            {r_rd, r_qd} <= n_lane_d;
        end
    end

    assign o_done  = r_done;
    assign o_q_num = r_qn;
    assign o_q_den = r_qd;

endmodule

// ===== hw/rtl/fra_dp.sv =====
`timescale 1ns / 1ps

module fra_dp import fra_pkg::*; #(
    parameter int W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic        [1:0]           i_action,
    input  logic signed [W-1:0]         i_a_num,
    input  logic signed [W-1:0]         i_a_den,
    input  logic signed [W-1:0]         i_b_num,
    input  logic signed [W-1:0]         i_b_den,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [RES_NUM_W-1:0] o_res_num,
    output logic        [RES_DEN_W-1:0] o_res_den
);

    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int EW = (MW > RES_NUM_W) ? MW : RES_NUM_W;

    logic [1:0]   r_act;
    logic [W-1:0] r_an_raw;
    logic [W-1:0] r_ad_raw;
    logic [W-1:0] r_bn_raw;
    logic [W-1:0] r_bd_raw;
    logic         r_a_neg;
    logic         r_b_neg;
    logic [W-1:0] r_a_num;
    logic [W-1:0] r_a_den;
    logic [W-1:0] r_b_num;
    logic [W-1:0] r_b_den;
    logic [PW-1:0] r_p0;
    logic [PW-1:0] r_p1;
    logic          r_w_neg;
    logic [MW-1:0] r_w_num;
    logic [MW-1:0] r_w_den;
    logic                  r_out_valid;
    logic [RES_NUM_W-1:0]  r_res_num;
    logic [RES_DEN_W-1:0]  r_res_den;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Operand normalization: sign and magnitude, zero denominator taken as one.
    logic [W-1:0] ld_nraw;
    logic [W-1:0] ld_draw;
    logic [W-1:0] ld_nmag;
    logic [W-1:0] ld_dmag;
    logic         ld_neg;

    always_comb begin
        ld_nraw = (i_cmd.op == OP_LOAD_B) ? r_bn_raw : r_an_raw;
        ld_draw = (i_cmd.op == OP_LOAD_B) ? r_bd_raw : r_ad_raw;
        ld_nmag = mag_of(ld_nraw);
        ld_dmag = (ld_draw == '0) ? {{(W-1){1'b0}}, 1'b1} : mag_of(ld_draw);
        ld_neg  = (ld_nraw[W-1] ^ ld_draw[W-1]) && (ld_nmag != '0);
    end

    // One shared multiplier, registered into its destination.
    logic [W-1:0]  mul_x;
    logic [W-1:0]  mul_y;
    logic [PW-1:0] prod;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL0: begin
                mul_x = r_a_num;
                mul_y = r_act[ACT_MUL_BIT] ? r_b_num : r_b_den;
            end
            OP_MUL1: begin
                mul_x = r_a_den;
                mul_y = r_b_num;
            end
            default: begin
                mul_x = r_a_den;
                mul_y = r_b_den;
            end
        endcase
        prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
    end

    // Combine the cross products in sign-magnitude.
    logic [MW-1:0] p0e;
    logic [MW-1:0] p1e;
    logic [MW-1:0] sum;
    logic [MW:0]   diff;
    logic          b_sgn;
    logic [MW-1:0] cb_mag;
    logic          cb_sgn;
    logic          cb_neg;

    always_comb begin
        p0e   = {1'b0, r_p0};
        p1e   = {1'b0, r_p1};
        sum   = p0e + p1e;
        diff  = {1'b0, p0e} - {1'b0, p1e};
        b_sgn = (r_act == ACT_SUB) ? !r_b_neg : r_b_neg;
        if (r_act[ACT_MUL_BIT]) begin
            cb_mag = p0e;
            cb_sgn = r_a_neg ^ r_b_neg;
        end else if (r_a_neg == b_sgn) begin
            cb_mag = sum;
            cb_sgn = r_a_neg;
        end else if (!diff[MW]) begin
            cb_mag = diff[MW-1:0];
            cb_sgn = r_a_neg;
        end else begin
            cb_mag = ~diff[MW-1:0] + 1'b1;
            cb_sgn = b_sgn;
        end
        cb_neg = cb_sgn && (cb_mag != '0);
    end

    // Reduction units.
    logic          gcd_done;
    logic [MW-1:0] gcd_g;
    logic          div_done;
    logic [MW-1:0] q_num;
    logic [MW-1:0] q_den;

    fra_gcd #(.MW(MW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_GCD_GO),
        .i_x     (r_w_num),
        .i_y     (r_w_den),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    fra_div #(.MW(MW), .SW(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_GO),
        .i_short (i_cmd.div_short),
        .i_num   (r_w_num),
        .i_den   (r_w_den),
        .i_g     (gcd_g),
        .o_done  (div_done),
        .o_q_num (q_num),
        .o_q_den (q_den)
    );

    // Result formatting.
    logic [EW-1:0] num_ext;
    logic [EW-1:0] neg_ext;
    logic [EW-1:0] den_ext;

    assign num_ext = EW'(r_w_num);
    assign neg_ext = ~num_ext + 1'b1;
    assign den_ext = EW'(r_w_den);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_act    <= i_action;
                r_an_raw <= i_a_num;
                r_ad_raw <= i_a_den;
                r_bn_raw <= i_b_num;
                r_bd_raw <= i_b_den;
            end
            OP_LOAD_A, OP_LOAD_B: begin
                r_w_neg <= ld_neg;
                r_w_num <= MW'(ld_nmag);
                r_w_den <= MW'(ld_dmag);
            end
            OP_STORE_A: begin
                r_a_neg <= r_w_neg;
                r_a_num <= r_w_num[W-1:0];
                r_a_den <= r_w_den[W-1:0];
            end
            OP_STORE_B: begin
                r_b_neg <= r_w_neg;
                r_b_num <= r_w_num[W-1:0];
                r_b_den <= r_w_den[W-1:0];
            end
            OP_MUL0: r_p0 <= prod;
            OP_MUL1: r_p1 <= prod;
            OP_MUL2: begin
                r_w_den <= MW'(prod);
                r_w_num <= cb_mag;
                r_w_neg <= cb_neg;
            end
            OP_DIV_WB: begin
                r_w_num <= q_num;
                r_w_den <= q_den;
            end
            OP_OUT_LOAD: begin
                r_res_num <= r_w_neg ? neg_ext[RES_NUM_W-1:0] : num_ext[RES_NUM_W-1:0];
                r_res_den <= den_ext[RES_DEN_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.work_zero = (r_w_num == '0);
    assign o_sts.gcd_done  = gcd_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT_LOAD) |-> (!r_out_valid || i_out_ready))
        else $error("Result register loaded while an item was still waiting.");

endmodule

// ===== hw/rtl/fra_ctrl.sv =====
`timescale 1ns / 1ps

module fra_ctrl import fra_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_LOAD_A   = 11'b000_0000_0010,
        S_LOAD_B   = 11'b000_0000_0100,
        S_CHECK    = 11'b000_0000_1000,
        S_GCD_WAIT = 11'b000_0001_0000,
        S_DIV_WAIT = 11'b000_0010_0000,
        S_STORE    = 11'b000_0100_0000,
        S_MUL0     = 11'b000_1000_0000,
        S_MUL1     = 11'b001_0000_0000,
        S_MUL2     = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } t_state;

    // Which fraction the shared reduction sequence is working on.
    typedef enum logic [1:0] {
        STG_A = 2'b00,
        STG_B = 2'b01,
        STG_R = 2'b10
    } t_stage;

    t_state r_state;
    t_state n_state;
    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_state         = r_state;
        n_stage         = r_stage;
        o_cmd.op        = OP_NONE;
        o_cmd.div_short = (r_stage != STG_R);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_stage  = STG_A;
                    n_state  = S_LOAD_A;
                end
            end
            S_LOAD_A: begin
                o_cmd.op = OP_LOAD_A;
                n_state  = S_CHECK;
            end
            S_LOAD_B: begin
                o_cmd.op = OP_LOAD_B;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.work_zero) begin
                    n_state = S_STORE;
                end else begin
                    o_cmd.op = OP_GCD_GO;
                    n_state  = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (i_sts.gcd_done) begin
                    o_cmd.op = OP_DIV_GO;
                    n_state  = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_DIV_WB;
                    n_state  = S_STORE;
                end
            end
            S_STORE: begin
                unique case (r_stage)
                    STG_A: begin
                        o_cmd.op = OP_STORE_A;
                        n_stage  = STG_B;
                        n_state  = S_LOAD_B;
                    end
                    STG_B: begin
                        o_cmd.op = OP_STORE_B;
                        n_stage  = STG_R;
                        n_state  = S_MUL0;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_MUL0: begin
                o_cmd.op = OP_MUL0;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_CHECK;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= STG_A;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_gcd_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.gcd_done |-> r_state == S_GCD_WAIT)
        else $error("GCD finished while the controller was not waiting for it.");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == S_DIV_WAIT)
        else $error("Divider finished while the controller was not waiting for it.");

endmodule

// ===== hw/rtl/fraction_arith_reduce_top.sv =====
`timescale 1ns / 1ps

// Fraction arithmetic with GCD reduction. Each input item carries two signed
// fractions a and b and an action (add, subtract a minus b, or multiply; the
// undefined action code behaves as multiply). A zero denominator is taken as one,
// a negative denominator moves its sign to the numerator, and each operand is
// reduced before the cross products are formed at full width, so nothing wraps.
// The result is reduced again and comes out as a signed numerator over a positive
// denominator; a zero numerator is not reduced, so its denominator is the product
// of the reduced operand denominators. Items are processed one at a time. From
// acceptance to the result register an item passes through the sequencing steps,
// the restoring divider and the shared binary GCD unit, which makes one shift or
// one subtract per cycle and needs at most two iterations per bit of its two
// inputs; a zero numerator skips the GCD unit and the divider. The restoring
// divider yields one quotient bit per cycle (OPERAND_WIDTH steps for each operand,
// 2*OPERAND_WIDTH+1 steps for the result). The result sits in an output register,
// so the next item is accepted while the previous result still waits to be taken;
// the block only stalls at the end of an item when the previous result has not
// been taken yet. Numerators and denominators that exceed the output field widths
// at larger OPERAND_WIDTH settings are truncated.
module fraction_arith_reduce_top import fra_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fra_in_if.sink    i_req,
    fra_out_if.source o_res
);

    // The controller sequences the datapath; the two only share commands and status.
    t_dp_cmd cmd;
    t_dp_sts sts;

    fra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath holds the operands, the shared multiplier, the GCD unit, the
    // divider and the output register.
    fra_dp #(.W(OPERAND_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_req.action),
        .i_a_num     (i_req.a_num),
        .i_a_den     (i_req.a_den),
        .i_b_num     (i_req.b_num),
        .i_b_den     (i_req.b_den),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_res_num   (o_res.res_num),
        .o_res_den   (o_res.res_den)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Checks fraction arithmetic with GCD reduction. Each item carries two signed
// fractions and an action. Every accepted item is run through a local predictor,
// and the predicted reduced fraction is queued. Each result that the block hands
// over is compared with the oldest entry in that queue.
module testbench import fra_pkg::*; ();

    localparam int OPW = 16;

    // Action codes. Subtract and the multiply select bit come from the package.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_MUL   = 2'd2;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 300;

    // No stalls on either side while this many items have been counted.
    localparam int STEADY_FROM = 400;
    localparam int STEADY_TO   = 600;

    typedef struct {
        logic [1:0]     action;
        logic [OPW-1:0] a_num;
        logic [OPW-1:0] a_den;
        logic [OPW-1:0] b_num;
        logic [OPW-1:0] b_den;
    } t_fraction_request;

    typedef struct {
        logic signed [RES_NUM_W-1:0] res_num;
        logic        [RES_DEN_W-1:0] res_den;
    } t_reduced_fraction;

    // A fraction as a sign and two magnitudes.
    typedef struct {
        bit              neg;
        longint unsigned num;
        longint unsigned den;
    } t_sign_mag_fraction;

    logic i_clk;
    logic i_rst_n;

    fra_in_if #(.OPERAND_WIDTH(OPW)) req_if ();
    fra_out_if                       res_if ();

    fraction_arith_reduce_top #(
        .OPERAND_WIDTH(OPW)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    t_fraction_request pending_requests[$];
    t_reduced_fraction expected_fractions[$];

    int sent_count     = 0;
    int received_count = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // A zero denominator counts as one, the denominator's sign moves to the
    // numerator, and a nonzero numerator is divided down by the GCD.
    function automatic t_sign_mag_fraction reduce_fraction(bit nneg, longint unsigned nmag,
                                                           bit dneg, longint unsigned dmag);
        t_sign_mag_fraction f;
        longint unsigned    g;
        if (dmag == 0) begin
            dmag = 1;
            dneg = 1'b0;
        end
        f.neg = (nneg != dneg) && (nmag != 0);
        f.num = nmag;
        f.den = dmag;
        if (nmag != 0) begin
            g     = gcd_of(nmag, dmag);
            f.num = nmag / g;
            f.den = dmag / g;
        end
        return f;
    endfunction

    function automatic t_sign_mag_fraction operand_fraction(logic [OPW-1:0] num_raw,
                                                            logic [OPW-1:0] den_raw);
        logic [OPW-1:0] nm;
        logic [OPW-1:0] dm;
        // The most negative value negates to itself, which is the right magnitude
        // when read as unsigned.
        nm = num_raw[OPW-1] ? (~num_raw + 1'b1) : num_raw;
        dm = den_raw[OPW-1] ? (~den_raw + 1'b1) : den_raw;
        return reduce_fraction(num_raw[OPW-1], 64'(nm), den_raw[OPW-1], 64'(dm));
    endfunction

    function automatic t_reduced_fraction compute_fraction_result(t_fraction_request rq);
        t_sign_mag_fraction a;
        t_sign_mag_fraction b;
        t_sign_mag_fraction r;
        t_reduced_fraction  res;
        longint unsigned    rn;
        longint unsigned    rd;
        longint unsigned    m1;
        longint unsigned    m2;
        bit                 rs;
        bit                 bs;
        a  = operand_fraction(rq.a_num, rq.a_den);
        b  = operand_fraction(rq.b_num, rq.b_den);
        rd = a.den * b.den;
        if (rq.action[ACT_MUL_BIT]) begin
            rn = a.num * b.num;
            rs = (a.neg != b.neg) && (rn != 0);
        end else begin
            bs = (rq.action == ACT_SUB) ? !b.neg : b.neg;
            m1 = a.num * b.den;
            m2 = a.den * b.num;
            if (a.neg == bs) begin
                rs = a.neg;
                rn = m1 + m2;
            end else if (m1 >= m2) begin
                rs = a.neg;
                rn = m1 - m2;
            end else begin
                rs = bs;
                rn = m2 - m1;
            end
            if (rn == 0)
                rs = 1'b0;
        end
        r = reduce_fraction(rs, rn, 1'b0, rd);
        res.res_num = r.neg ? (~r.num + 1) : r.num;
        res.res_den = r.den;
        return res;
    endfunction

    task automatic add_request(logic [1:0] act, int an, int ad, int bn, int bd);
        t_fraction_request rq;
        rq.action = act;
        rq.a_num  = an[OPW-1:0];
        rq.a_den  = ad[OPW-1:0];
        rq.b_num  = bn[OPW-1:0];
        rq.b_den  = bd[OPW-1:0];
        pending_requests.push_back(rq);
    endtask

    // Half of the values span the full range; small values, scaled small values
    // and extremes are mixed in so that reductions and exact zeros happen often.
    function automatic int pick_operand();
        int choice;
        choice = $urandom_range(9);
        case (choice)
            0: begin
                case ($urandom_range(5))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return 1;
                    4: return -1;
                    default: return -32767;
                endcase
            end
            1, 2, 3: return int'($urandom_range(40)) - 20;
            4: return (int'($urandom_range(24)) - 12) * (1 << $urandom_range(10));
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic logic [1:0] pick_action();
        if ($urandom_range(15) == 0)
            return ACT_UNDEF;
        return 2'($urandom_range(2));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: takes the item off the request pins at acceptance, predicts its
    // result, then presents the next pending item unless it decides to idle.
    always @(posedge i_clk) begin
        t_fraction_request rq;
        bit                idle;
        if (!i_rst_n) begin
            req_if.valid  <= 1'b0;
            req_if.action <= '0;
            req_if.a_num  <= '0;
            req_if.a_den  <= '0;
            req_if.b_num  <= '0;
            req_if.b_den  <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                rq.action = req_if.action;
                rq.a_num  = req_if.a_num;
                rq.a_den  = req_if.a_den;
                rq.b_num  = req_if.b_num;
                rq.b_den  = req_if.b_den;
                expected_fractions.push_back(compute_fraction_result(rq));
                sent_count++;
            end
            if (!req_if.valid || req_if.ready) begin
                idle = !(sent_count >= STEADY_FROM && sent_count < STEADY_TO)
                       && ($urandom_range(99) < 27);
                if (pending_requests.size() > 0 && !idle) begin
                    rq = pending_requests.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.action <= rq.action;
                    req_if.a_num  <= rq.a_num;
                    req_if.a_den  <= rq.a_den;
                    req_if.b_num  <= rq.b_num;
                    req_if.b_den  <= rq.b_den;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction and stalls the
    // result side at random.
    always @(posedge i_clk) begin
        t_reduced_fraction want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                received_count++;
                if (expected_fractions.size() == 0) begin
                    error_count++;
                    $display("%0t: result %0d/%0d with no item outstanding",
                             $time, res_if.res_num, res_if.res_den);
                end else begin
                    want = expected_fractions.pop_front();
                    if (res_if.res_num !== want.res_num) begin
                        error_count++;
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, want.res_num, res_if.res_num);
                    end
                    if (res_if.res_den !== want.res_den) begin
                        error_count++;
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, want.res_den, res_if.res_den);
                    end
                end
            end
            res_if.ready <= (received_count >= STEADY_FROM && received_count < STEADY_TO)
                            || ($urandom_range(99) >= 27);
        end
    end

    initial begin
        // Plain cases for each action, including the undefined code.
        add_request(ACT_ADD, 1, 2, 1, 3);
        add_request(ACT_SUB, 3, 4, 1, 6);
        add_request(ACT_MUL, 2, 3, 3, 4);
        add_request(ACT_UNDEF, 5, 7, 7, 5);
        // Zero denominators are taken as one.
        add_request(ACT_ADD, 3, 0, 1, 0);
        add_request(ACT_SUB, 0, 0, 0, 0);
        // Negative denominators hand their sign to the numerator.
        add_request(ACT_SUB, 1, -2, 3, -4);
        add_request(ACT_MUL, -5, -6, 7, -9);
        // A zero numerator keeps the product of the operand denominators.
        add_request(ACT_SUB, 1, 2, 1, 2);
        add_request(ACT_ADD, 0, 5, 0, -7);
        add_request(ACT_MUL, 0, 3, 5, 0);
        add_request(ACT_UNDEF, 12, 8, 0, 30);
        // The most negative value and the largest positive one.
        add_request(ACT_MUL, -32768, -32768, -32768, 1);
        add_request(ACT_MUL, -32768, 1, -32768, 1);
        add_request(ACT_ADD, -32768, 32767, -32768, 32767);
        add_request(ACT_SUB, 32767, -32768, -32768, 32767);
        add_request(ACT_ADD, 32767, -32768, -32768, 32767);
        add_request(ACT_MUL, 32767, 1, 32767, 1);
        add_request(ACT_ADD, 32767, 1, 32767, 1);
        add_request(ACT_SUB, -32768, 1, 32767, 1);
        add_request(ACT_MUL, 1, 32767, 1, -32768);
        add_request(ACT_ADD, 1, 32767, -1, 32768 - 65536);
        add_request(ACT_SUB, 32767, 32767, -32768, -32768);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_request(pick_action(), pick_operand(), pick_operand(),
                        pick_operand(), pick_operand());

        do
            @(posedge i_clk);
        while (pending_requests.size() != 0 || req_if.valid
               || expected_fractions.size() != 0);

        // Let any stray extra result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_fractions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
